// ===== hdl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// shared types and constants of the convex hull trick dp engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cht_pkg;

    localparam int CHT_MAX_LINES = 1024;

    localparam logic [1:0] CFG_QUAD  = 2'd0;
    localparam logic [1:0] CFG_LIN   = 2'd1;
    localparam logic [1:0] CFG_CONST = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AP,
        ST_AP2,
        ST_AP3,
        ST_BP,
        ST_QCHK,
        ST_QRD1,
        ST_QE1,
        ST_QE2,
        ST_QFIN,
        ST_QF1,
        ST_QF2,
        ST_SUM,
        ST_SUM2,
        ST_SUM3,
        ST_PUSH,
        ST_PCHK,
        ST_PR1,
        ST_PR2,
        ST_PR3,
        ST_PR4,
        ST_DONE,
        ST_MULW
    } cht_state_t;

    // signed less-than on wrapped 64-bit words
    function automatic logic slt64(input logic [63:0] x, input logic [63:0] y);
        return $signed(x) < $signed(y);
    endfunction

endpackage

// ===== hdl/cht_mul.sv =====
// ----------------------------------------------------------------------------
// cht_mul
// iterative 64x64 multiplier, low 64 bits, one 32x32 partial product a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_mul
    import cht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] pp;

    // one 32x32 multiplier, operand halves picked by the step
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            2'd1:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            default:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
        endcase
    end

    assign pp = {32'd0, mul_x} * {32'd0, mul_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= 2'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:    acc_reg <= pp;
                2'd1:    acc_reg[63:32] <= acc_reg[63:32] + pp[31:0];
                default: acc_reg[63:32] <= acc_reg[63:32] + pp[31:0];
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== hdl/convex_hull_trick_dp.sv =====
// ----------------------------------------------------------------------------
// convex_hull_trick_dp
// streaming dp engine with a monotone-slope line stack
// ----------------------------------------------------------------------------
// usage:
//   configuration: cfg_we / cfg_addr / cfg_data write quad_coeff (0),
//   lin_coeff (1) and const_term (2); write only while the block is idle
//   input channel in_valid / in_ready carries start_seq and item_value
//   output channel out_valid / out_ready carries best_value and hull_overflow
//   one result item per input item, in order
// latency and throughput:
//   every 64-bit product goes through one shared multiplier taking three
//   32x32 partial products, five cycles a use counting the issuing state
//   an item takes roughly 31 + 12*probes + 13*pops cycles, plus 12 for the
//   last removal test once three or more lines are held; probes is about
//   log2(lines held) + 1 binary search steps and pops the lines removed
//   in_ready is high only in idle; one item is worked on at a time
// reset:
//   rst_n clears coefficients, prefix sum, line count and overflow flag;
//   the line store needs no clearing pass as only entries below the count
//   are read
// stalls:
//   a finished result sits in the output register; a new item is taken
//   while it waits, and the next result waits until the slot is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module convex_hull_trick_dp
    import cht_pkg::*;
#(
    parameter int MAX_LINES = CHT_MAX_LINES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               start_seq,
    input  logic [15:0]        item_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] best_value,
    output logic               hull_overflow
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int SW = CW + 1;

    // configuration
    logic [15:0] quad_reg;
    logic [31:0] lin_reg;
    logic [31:0] const_reg;
    logic [63:0] a_ext;
    logic [63:0] b_ext;
    logic [63:0] c_ext;

    // state
    cht_state_t state_reg, state_next, ret_reg, ret_target;
    logic [63:0]   p_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;

    // datapath scratch
    logic [63:0] t_reg, app_reg, bp_reg, m_reg, q_reg;
    logic [63:0] qi_reg, v1_reg, best_val_reg, s_reg, dp_reg;
    logic [63:0] m1_reg, q1_reg, d2_reg, e2_reg, lhs_reg;
    logic signed [SW-1:0] lo_reg, hi_reg;
    logic [CW-1:0] mid_reg, best_reg;

    // output slot
    logic        out_valid_reg;
    logic [63:0] out_value_reg;
    logic        out_ovf_reg;

    // shared multiplier
    logic        mul_start;
    logic [63:0] mul_a, mul_b;
    logic        mul_done;
    logic [63:0] mul_p;

    // line store, slope in the upper half
    logic [127:0]  mem [MAX_LINES];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [127:0]  mem_wdata, rd_data;
    logic [63:0]   rd_m, rd_q;

    logic          accept;
    logic          out_free;
    logic [SW:0]   mid_sum;
    logic [CW-1:0] mid_c;
    logic [CW:0]   mid_p1;
    logic [63:0]   v2;
    logic          search_on;

    assign a_ext = {{48{quad_reg[15]}}, quad_reg};
    assign b_ext = {{32{lin_reg[31]}}, lin_reg};
    assign c_ext = {{32{const_reg[31]}}, const_reg};
    assign rd_m  = rd_data[127:64];
    assign rd_q  = rd_data[63:0];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // midpoint; lo and hi are both non-negative whenever a probe is taken
    assign search_on = (lo_reg <= hi_reg);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c     = mid_sum[CW:1];
    assign mid_p1    = {1'b0, mid_c} + {{CW{1'b0}}, 1'b1};
    assign v2        = mul_p + qi_reg;

    cht_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // line store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data <= mem[mem_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_AP;
            ST_AP:   state_next = ST_MULW;
            ST_AP2:  state_next = ST_MULW;
            ST_AP3:  state_next = ST_MULW;
            ST_BP:   state_next = (count_reg == '0) ? ST_SUM : ST_QCHK;
            ST_QCHK:
            begin
                if (!search_on)
                    state_next = ST_QFIN;
                else if (mid_p1 < {1'b0, count_reg})
                    state_next = ST_QRD1;
            end
            ST_QRD1: state_next = ST_MULW;
            ST_QE1:  state_next = ST_MULW;
            ST_QE2:  state_next = ST_QCHK;
            ST_QFIN: state_next = ST_QF1;
            ST_QF1:  state_next = ST_MULW;
            ST_QF2:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SUM2;
            ST_SUM2: state_next = ST_SUM3;
            ST_SUM3: state_next = ST_PUSH;
            ST_PUSH: state_next = (count_reg >= CW'(MAX_LINES)) ? ST_DONE : ST_PCHK;
            ST_PCHK: state_next = (count_reg >= CW'(3)) ? ST_PR1 : ST_DONE;
            ST_PR1:  state_next = ST_PR2;
            ST_PR2:  state_next = ST_MULW;
            ST_PR3:  state_next = ST_MULW;
            ST_PR4:  state_next = slt64(lhs_reg, mul_p) ? ST_PCHK : ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            ST_MULW: if (mul_done) state_next = ret_reg;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        mul_start  = 1'b0;
        mul_a      = p_reg;
        mul_b      = p_reg;
        ret_target = ST_IDLE;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = {m_reg, q_reg};
        mem_re     = 1'b0;
        mem_raddr  = mid_c[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                // seed line (0,0) on a new sequence
                mem_we    = accept && start_seq;
                mem_wdata = '0;
            end
            ST_AP:
            begin
                mul_start  = 1'b1;
                mul_a      = a_ext;
                ret_target = ST_AP2;
            end
            ST_AP2:
            begin
                mul_start  = 1'b1;
                mul_a      = mul_p;
                ret_target = ST_AP3;
            end
            ST_AP3:
            begin
                mul_start  = 1'b1;
                mul_a      = b_ext;
                ret_target = ST_BP;
            end
            ST_QCHK:
            begin
                mem_re    = search_on && (mid_p1 < {1'b0, count_reg});
                mem_raddr = mid_c[AW-1:0];
            end
            ST_QRD1:
            begin
                mul_start  = 1'b1;
                mul_a      = rd_m;
                ret_target = ST_QE1;
                mem_re     = 1'b1;
                mem_raddr  = mid_p1[AW-1:0];
            end
            ST_QE1:
            begin
                mul_start  = 1'b1;
                mul_a      = rd_m;
                ret_target = ST_QE2;
            end
            ST_QFIN:
            begin
                mem_re    = 1'b1;
                mem_raddr = best_reg[AW-1:0];
            end
            ST_QF1:
            begin
                mul_start  = 1'b1;
                mul_a      = rd_m;
                ret_target = ST_QF2;
            end
            ST_PUSH:
            begin
                mem_we    = (count_reg < CW'(MAX_LINES));
                mem_waddr = count_reg[AW-1:0];
            end
            ST_PCHK:
            begin
                mem_re    = (count_reg >= CW'(3));
                mem_raddr = AW'(count_reg - CW'(3));
            end
            ST_PR1:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(count_reg - CW'(2));
            end
            ST_PR2:
            begin
                mul_start  = 1'b1;
                mul_a      = q_reg - q1_reg;
                mul_b      = m1_reg - rd_m;
                ret_target = ST_PR3;
            end
            ST_PR3:
            begin
                mul_start  = 1'b1;
                mul_a      = d2_reg;
                mul_b      = e2_reg;
                ret_target = ST_PR4;
            end
            ST_PR4:
            begin
                // middle line dropped, newest line moves down
                mem_we    = slt64(lhs_reg, mul_p);
                mem_waddr = AW'(count_reg - CW'(2));
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            quad_reg      <= '0;
            lin_reg       <= '0;
            const_reg     <= '0;
            p_reg         <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start)
                ret_reg <= ret_target;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_QUAD:  quad_reg  <= cfg_data[15:0];
                    CFG_LIN:   lin_reg   <= cfg_data;
                    CFG_CONST: const_reg <= cfg_data;
                    default:   quad_reg  <= quad_reg;
                endcase
            end
            if (accept)
            begin
                if (start_seq)
                begin
                    p_reg     <= {48'd0, item_value};
                    count_reg <= CW'(1);
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    p_reg <= p_reg + {48'd0, item_value};
                end
            end
            if (state_reg == ST_PUSH)
            begin
                if (count_reg >= CW'(MAX_LINES))
                    ovf_reg <= 1'b1;
                else
                    count_reg <= count_reg + CW'(1);
            end
            if (state_reg == ST_PR4 && slt64(lhs_reg, mul_p))
                count_reg <= count_reg - CW'(1);
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_AP2: t_reg   <= mul_p;
            ST_AP3: app_reg <= mul_p;
            ST_BP:
            begin
                bp_reg       <= mul_p;
                m_reg        <= 64'd0 - {t_reg[62:0], 1'b0};
                lo_reg       <= '0;
                hi_reg       <= $signed({1'b0, count_reg}) - SW'(1);
                best_reg     <= '0;
                best_val_reg <= '0;
            end
            ST_QCHK:
            begin
                mid_reg <= mid_c;
                if (search_on && !(mid_p1 < {1'b0, count_reg}))
                    hi_reg <= $signed({1'b0, mid_c}) - SW'(1);
            end
            ST_QRD1: qi_reg <= rd_q;
            ST_QE1:
            begin
                v1_reg <= mul_p + qi_reg;
                qi_reg <= rd_q;
            end
            ST_QE2:
            begin
                if (slt64(v1_reg, v2))
                begin
                    best_reg <= mid_reg + CW'(1);
                    lo_reg   <= $signed({1'b0, mid_reg}) + SW'(1);
                end
                else
                begin
                    hi_reg <= $signed({1'b0, mid_reg}) - SW'(1);
                end
            end
            ST_QF1: qi_reg       <= rd_q;
            ST_QF2: best_val_reg <= v2;
            ST_SUM:  s_reg  <= best_val_reg + app_reg;
            ST_SUM2: dp_reg <= s_reg + bp_reg + c_ext;
            ST_SUM3: q_reg  <= dp_reg + app_reg - bp_reg;
            ST_PR1:
            begin
                m1_reg <= rd_m;
                q1_reg <= rd_q;
            end
            ST_PR2:
            begin
                d2_reg <= rd_q - q1_reg;
                e2_reg <= m1_reg - m_reg;
            end
            ST_PR3: lhs_reg <= mul_p;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_value_reg <= dp_reg;
                    out_ovf_reg   <= ovf_reg;
                end
            end
            default: s_reg <= s_reg;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign best_value    = $signed(out_value_reg);
    assign hull_overflow = out_ovf_reg;

endmodule
